// ===== rtl/lpps_pkg.sv =====
// lpps_pkg: shared types, constants and helpers for the line position / PD steering core.
// No dependencies; imported by every module under rtl/.
`timescale 1ns / 1ps

package lpps_pkg;

  // Array geometry
  localparam int SENSOR_COUNT = 5;
  localparam int FIELD_COUNT  = 5;
  localparam int LANE_COUNT   = (SENSOR_COUNT > FIELD_COUNT) ? FIELD_COUNT : SENSOR_COUNT;

  // Field widths
  localparam int SENS_W   = 10;
  localparam int WGT_W    = 12;
  localparam int PROD_W   = SENS_W + WGT_W;
  localparam int WEIGHT_W = 24;
  localparam int TOTAL_W  = 13;
  localparam int POS_W    = 12;
  localparam int ERR_W    = 12;
  localparam int STEER_W  = 16;
  localparam int CLS_W    = 2;
  localparam int CDIFF_W  = 18;

  // Serial divider
  localparam int DIV_STEPS = POS_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int REM_PAD_W = TOTAL_W - (WEIGHT_W - POS_W);

  // Divide by three: x * ceil(2^17 / 3) >> 17, exact for x < 2^17
  localparam int MAG_W       = ERR_W - 1;
  localparam int RECIP_SHIFT = 17;
  localparam int RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'(43691);
  localparam int RPROD_W     = MAG_W + RECIP_W;

  // Arithmetic constants
  localparam int FULL_SCALE  = 1000;
  localparam int CENTRE      = 2000;
  localparam int BLACK_LIMIT = 400;
  localparam int GREEN_LIMIT = -1;
  localparam int SUM_GAIN    = 12;
  localparam int FULL_POS    = (LANE_COUNT - 1) * FULL_SCALE;
  localparam int LOST_SPLIT  = FULL_POS / 2;
  localparam int NOISE_RESET = 50;

  // Colour class codes
  localparam logic [CLS_W-1:0] COLOUR_UNKNOWN = 2'd0;
  localparam logic [CLS_W-1:0] COLOUR_BLACK   = 2'd1;
  localparam logic [CLS_W-1:0] COLOUR_GREEN   = 2'd2;

  // Configuration map
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_INVERT = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_THRESH = 1'b1;

  typedef struct packed {
    logic [SENS_W-1:0] sensor_0;
    logic [SENS_W-1:0] sensor_1;
    logic [SENS_W-1:0] sensor_2;
    logic [SENS_W-1:0] sensor_3;
    logic [SENS_W-1:0] sensor_4;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]          position;
    logic                      line_seen;
    logic signed [STEER_W-1:0] steer;
    logic [CLS_W-1:0]          colour_class;
  } out_item_t;

  typedef struct packed {
    logic              hit;
    logic [SENS_W-1:0] val;
    logic [PROD_W-1:0] prod;
  } lane_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

  function automatic logic [WGT_W-1:0] lane_weight(input int idx);
    lane_weight = WGT_W'(idx * FULL_SCALE);
  endfunction

endpackage

// ===== rtl/lpps_lane.sv =====
// lpps_lane: one sensor lane - optional inversion, threshold test, weighted product.
// Depends on lpps_pkg.
`timescale 1ns / 1ps

module lpps_lane (
  input  logic [lpps_pkg::SENS_W-1:0] raw,
  input  logic                        invert,
  input  logic [lpps_pkg::SENS_W-1:0] threshold,
  input  logic [lpps_pkg::WGT_W-1:0]  weight,
  output lpps_pkg::lane_out_t         lane_o
);
  import lpps_pkg::*;

  localparam int V_W = SENS_W + 2;

  logic signed [V_W-1:0] v_s;
  logic signed [V_W-1:0] thr_s;
  logic [SENS_W-1:0]     val;

  always_comb begin
    // inverted readings above full scale go negative and never count
    v_s   = invert ? (V_W'(FULL_SCALE) - $signed({2'b00, raw})) : $signed({2'b00, raw});
    thr_s = $signed({2'b00, threshold});
    lane_o.hit  = (v_s > thr_s);
    val         = lane_o.hit ? v_s[SENS_W-1:0] : '0;
    lane_o.val  = val;
    lane_o.prod = val * weight;
  end

endmodule

// ===== rtl/lpps_merge.sv =====
// lpps_merge: combines lane results into hit flag, reading total and weighted sum.
// Depends on lpps_pkg.
`timescale 1ns / 1ps

module lpps_merge (
  input  lpps_pkg::lane_out_t           lanes [lpps_pkg::LANE_COUNT],
  output logic                          seen,
  output logic [lpps_pkg::TOTAL_W-1:0]  total,
  output logic [lpps_pkg::WEIGHT_W-1:0] weighted
);
  import lpps_pkg::*;

  always_comb begin
    seen     = 1'b0;
    total    = '0;
    weighted = '0;
    for (int i = 0; i < LANE_COUNT; i++) begin
      seen     = seen | lanes[i].hit;
      total    = total + TOTAL_W'(lanes[i].val);
      weighted = weighted + WEIGHT_W'(lanes[i].prod);
    end
  end

endmodule

// ===== rtl/lpps_divider.sv =====
// lpps_divider: restoring divider, one quotient bit per cycle.
// Quotient must fit POS_W bits (dividend < divisor * 2^POS_W). Depends on lpps_pkg.
`timescale 1ns / 1ps

module lpps_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lpps_pkg::WEIGHT_W-1:0] dividend,
  input  logic [lpps_pkg::TOTAL_W-1:0]  divisor,
  output lpps_pkg::div_stat_t           stat,
  output logic [lpps_pkg::POS_W-1:0]    quotient
);
  import lpps_pkg::*;

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [TOTAL_W-1:0] rem_r;
  logic [TOTAL_W-1:0] div_r;
  logic [POS_W-1:0]   lo_r;
  logic [POS_W-1:0]   quo_r;

  logic [TOTAL_W:0]   trial;
  logic               fits;

  always_comb begin
    trial = {rem_r, lo_r[POS_W-1]};
    fits  = (trial >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // upper dividend bits are already below the divisor
      rem_r <= {{REM_PAD_W{1'b0}}, dividend[WEIGHT_W-1:POS_W]};
      lo_r  <= dividend[POS_W-1:0];
      div_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? TOTAL_W'(trial - {1'b0, div_r}) : trial[TOTAL_W-1:0];
      lo_r  <= {lo_r[POS_W-2:0], 1'b0};
      quo_r <= {quo_r[POS_W-2:0], fits};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ===== rtl/line_position_pd_steering_core.sv =====
// line_position_pd_steering_core: top level - line position, PD steering and colour class.
// Depends on lpps_pkg, lpps_lane, lpps_merge, lpps_divider.
`timescale 1ns / 1ps

// Channel   Dir  Handshake               Payload
// in_       in   in_valid / in_ready     lpps_pkg::in_item_t  (sensor_0 .. sensor_4)
// out_      out  out_valid / out_ready   lpps_pkg::out_item_t (position, line_seen, steer,
//                                                               colour_class)
// cfg       in   psel/penable/pwrite     APB, reg 0 invert (addr 0), reg 1 threshold (addr 4)
//
// One request at a time: accept, lane merge, serial divide (12 quotient steps plus the
// done flag; skipped when no lane sees the line), position / divide-by-three, result.
// in_ready returns in the same cycle that out_valid rises.
// rst_n is synchronous, active low; clears control, history and the config registers.
// The result register frees the core: a new request is taken while the last result waits.
// A stalled result holds the core in its final state until the register drains.

module line_position_pd_steering_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lpps_pkg::in_item_t              in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output lpps_pkg::out_item_t             out_data,
  // configuration (APB)
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lpps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [lpps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [lpps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import lpps_pkg::*;

  // ---------------------------------------------------------------- config
  logic              invert_r;
  logic [SENS_W-1:0] thresh_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
      thresh_r <= SENS_W'(NOISE_RESET);
    end else if (cfg_wr) begin
      unique case (paddr[CFG_ADDR_W-1:2])
        REG_INVERT: invert_r <= pwdata[0];
        REG_THRESH: thresh_r <= pwdata[SENS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[CFG_ADDR_W-1:2])
      REG_INVERT: prdata = {{(CFG_DATA_W-1){1'b0}}, invert_r};
      REG_THRESH: prdata = {{(CFG_DATA_W-SENS_W){1'b0}}, thresh_r};
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- control
  state_t state_r, state_nxt;
  logic   out_free;
  logic   div_start;
  logic   load_out;
  div_stat_t div_stat;

  // request capture and per-item registers
  in_item_t                 in_r;
  logic                     seen_r;
  logic [TOTAL_W-1:0]       raw_sum_r;
  logic [POS_W-1:0]         pos_r;
  logic signed [ERR_W-1:0]  err_r;
  logic                     err_neg_r;
  logic [MAG_W-1:0]         q3_r;

  // history
  logic [POS_W-1:0]         last_position_r;
  logic signed [ERR_W-1:0]  last_error_r;
  logic [TOTAL_W-1:0]       last_sum_r;

  // result register
  logic                     out_valid_r;
  out_item_t                out_r;

  // lanes and merge
  logic [SENS_W-1:0]  raw_a [FIELD_COUNT];
  lane_out_t          lanes [LANE_COUNT];
  logic               m_seen;
  logic [TOTAL_W-1:0] m_total;
  logic [WEIGHT_W-1:0] m_weighted;
  logic [POS_W-1:0]   quo;

  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_SUM;
      S_SUM: begin
        // lost line skips the divide
        div_start = m_seen;
        state_nxt = m_seen ? S_DIV : S_FIN;
      end
      S_DIV:  if (div_stat.done) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- lanes
  always_comb begin
    raw_a[0] = in_r.sensor_0;
    raw_a[1] = in_r.sensor_1;
    raw_a[2] = in_r.sensor_2;
    raw_a[3] = in_r.sensor_3;
    raw_a[4] = in_r.sensor_4;
  end

  for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
    lpps_lane u_lane (
      .raw       (raw_a[g]),
      .invert    (invert_r),
      .threshold (thresh_r),
      .weight    (lane_weight(g)),
      .lane_o    (lanes[g])
    );
  end

  lpps_merge u_merge (
    .lanes    (lanes),
    .seen     (m_seen),
    .total    (m_total),
    .weighted (m_weighted)
  );

  lpps_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (m_weighted),
    .divisor  (m_total),
    .stat     (div_stat),
    .quotient (quo)
  );

  // ---------------------------------------------------------------- datapath
  logic [TOTAL_W-1:0]       raw_sum;
  logic [POS_W-1:0]         pos_fin;
  logic signed [ERR_W-1:0]  err_fin;
  logic [MAG_W-1:0]         mag_fin;
  logic [RPROD_W-1:0]       rprod;
  logic signed [STEER_W-1:0] q3_s;
  logic signed [ERR_W:0]    err_diff;
  logic signed [STEER_W-1:0] steer;
  logic signed [CDIFF_W-1:0] cdiff;
  logic [CLS_W-1:0]         cls;

  always_comb begin
    // colour sum always spans every field
    raw_sum = '0;
    for (int i = 0; i < FIELD_COUNT; i++) raw_sum = raw_sum + TOTAL_W'(raw_a[i]);

    if (seen_r)                                pos_fin = quo;
    else if (last_position_r < POS_W'(LOST_SPLIT)) pos_fin = '0;
    else                                       pos_fin = POS_W'(FULL_POS);

    err_fin = ERR_W'($signed({1'b0, pos_fin}) - (ERR_W + 1)'(CENTRE));
    mag_fin = err_fin[ERR_W-1] ? MAG_W'(-err_fin) : MAG_W'(err_fin);
    rprod   = mag_fin * RECIP3;

    // divide by three truncates toward zero: apply the sign to the magnitude quotient
    q3_s     = err_neg_r ? -$signed({{(STEER_W-MAG_W){1'b0}}, q3_r})
                         :  $signed({{(STEER_W-MAG_W){1'b0}}, q3_r});
    err_diff = (ERR_W + 1)'(err_r) - (ERR_W + 1)'(last_error_r);
    steer    = q3_s + (STEER_W'(err_diff) <<< 3);

    cdiff = CDIFF_W'(13) * $signed({{(CDIFF_W-TOTAL_W){1'b0}}, raw_sum_r})
          - CDIFF_W'(SUM_GAIN) * $signed({{(CDIFF_W-TOTAL_W){1'b0}}, last_sum_r});
    if (cdiff > CDIFF_W'(BLACK_LIMIT))      cls = COLOUR_BLACK;
    else if (cdiff > CDIFF_W'(GREEN_LIMIT)) cls = COLOUR_GREEN;
    else                                    cls = COLOUR_UNKNOWN;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_data;
    if (state_r == S_SUM) begin
      seen_r    <= m_seen;
      raw_sum_r <= raw_sum;
    end
    if (state_r == S_FIN) begin
      pos_r     <= pos_fin;
      err_r     <= err_fin;
      err_neg_r <= err_fin[ERR_W-1];
      q3_r      <= rprod[RPROD_W-1:RECIP_SHIFT];
    end
    if (load_out) begin
      out_r.position     <= pos_r;
      out_r.line_seen    <= seen_r;
      out_r.steer        <= steer;
      out_r.colour_class <= cls;
    end
  end

  // history updates: position only on a seen line, error and sum every request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_position_r <= '0;
      last_error_r    <= '0;
      last_sum_r      <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (state_r == S_FIN && seen_r) last_position_r <= quo;
      if (load_out) begin
        last_error_r <= err_r;
        last_sum_r   <= raw_sum_r;
      end
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/lpps_checker.sv =====
// lpps_checker: port-level assertions for line_position_pd_steering_core, with bind.
// Depends on lpps_pkg and the top-level port list.
`timescale 1ns / 1ps

module lpps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input lpps_pkg::out_item_t out_data
);
  import lpps_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request in flight: no second accept straight after the first
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while core busy");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.position <= POS_W'(FULL_POS))
    else $error("position out of range");

  // lost line snaps to an end of the array
  a_lost_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.line_seen |->
      out_data.position == '0 || out_data.position == POS_W'(FULL_POS))
    else $error("lost line not at an edge");

  a_colour_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.colour_class == COLOUR_UNKNOWN ||
                  out_data.colour_class == COLOUR_BLACK ||
                  out_data.colour_class == COLOUR_GREEN)
    else $error("bad colour class");

endmodule

bind line_position_pd_steering_core lpps_checker u_lpps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== verif/tb.sv =====
// tb: self-checking bench for line_position_pd_steering_core (position, PD steer, colour class).
// Depends on lpps_pkg and the core; uses a small class that predicts and holds expected results.
`timescale 1ns / 1ps

module tb;
  import lpps_pkg::*;

  // Own constants for the prediction, kept apart from the package names
  localparam int LINE_LANES = 5;
  localparam int LINE_FULL  = 1000;
  localparam int LINE_MID   = 2000;
  localparam int MAX_SHOWN  = 10;

  // ---------------------------------------------------------------------------
  // Prediction and checking
  // ---------------------------------------------------------------------------
  class steering_board;
    bit          invert;
    logic [9:0]  threshold;
    logic [11:0] last_pos;
    int          last_err;
    int          last_sum;
    out_item_t   expected_steer[$];
    int          fails;

    function new();
      invert    = 1'b0;
      threshold = 10'd50;
      last_pos  = '0;
      last_err  = 0;
      last_sum  = 0;
      fails     = 0;
    endfunction

    function void flag(string msg);
      fails++;
      if (fails <= MAX_SHOWN) $display("%s", msg);
    endfunction

    // Works out the result of one accepted frame and queues it
    function void note_frame(in_item_t f);
      int        s[LINE_LANES];
      int        v, weighted, total, rsum, err, steer, cdiff, i;
      bit        seen;
      logic [11:0] pos;
      out_item_t r;
      s = '{int'(f.sensor_0), int'(f.sensor_1), int'(f.sensor_2),
            int'(f.sensor_3), int'(f.sensor_4)};
      weighted = 0;
      total    = 0;
      rsum     = 0;
      seen     = 1'b0;
      for (i = 0; i < LINE_LANES; i++) begin
        rsum += s[i];
        v = invert ? LINE_FULL - s[i] : s[i];
        if (v > int'(threshold)) begin
          seen = 1'b1;
          weighted += v * i * LINE_FULL;
          total += v;
        end
      end
      if (seen && total != 0) begin
        pos = 12'(weighted / total);
        last_pos = pos;
      end else if (int'(last_pos) < (LINE_LANES - 1) * LINE_FULL / 2) begin
        pos = '0;
      end else begin
        pos = 12'((LINE_LANES - 1) * LINE_FULL);
      end
      // SV integer division truncates toward zero, as the steering law wants
      err = int'(pos) - LINE_MID;
      steer = err / 3 + 8 * (err - last_err);
      last_err = err;
      cdiff = rsum + 12 * (rsum - last_sum);
      last_sum = rsum;
      r.position  = pos;
      r.line_seen = seen;
      r.steer     = 16'(steer);
      if (cdiff > 400) r.colour_class = COLOUR_BLACK;
      else if (cdiff >= 0) r.colour_class = COLOUR_GREEN;
      else r.colour_class = COLOUR_UNKNOWN;
      expected_steer.push_back(r);
    endfunction

    function void check_output(out_item_t got);
      out_item_t want;
      if (expected_steer.size() == 0) begin
        flag($sformatf("unexpected result: pos %0d seen %0b steer %0d class %0d",
                       got.position, got.line_seen, got.steer, got.colour_class));
        return;
      end
      want = expected_steer.pop_front();
      if (got.position !== want.position || got.line_seen !== want.line_seen ||
          got.steer !== want.steer || got.colour_class !== want.colour_class)
        flag($sformatf({"result differs: expected pos %0d seen %0b steer %0d class %0d,",
                        " got pos %0d seen %0b steer %0d class %0d"},
                       want.position, want.line_seen, want.steer, want.colour_class,
                       got.position, got.line_seen, got.steer, got.colour_class));
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Signals and DUT
  // ---------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  steering_board sb = new();
  bit            gaps_on;   // random idling on both channels
  in_item_t      last_frame;

  line_position_pd_steering_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #10_000_000;
    $display("line_position_pd_steering_core: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Monitors: everything sampled at the rising edge, drive happens at the falling
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_frame(in_data);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_output(out_data);
  end

  // Result side: back-pressure about 22 percent of the time while gaps are on
  initial begin
    forever begin
      @(negedge clk);
      out_ready <= gaps_on ? ($urandom_range(99) >= 22) : 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One request: optional idle cycles, then valid held with a fixed payload until taken.
  // Valid is left high afterwards so back-to-back requests need no bubble.
  task automatic send_request(input in_item_t f);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (!in_ready);
    last_frame = f;
  endtask

  // Drop valid and hold off until every predicted result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_steer.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write then read-back of the same register; block must be idle
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_INVERT) sb.invert = value[0];
    else sb.threshold = value[9:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== value)
      sb.flag($sformatf("register %0d read back %0d, written %0d", idx, rd, value));
  endtask

  function automatic in_item_t mk_frame(input int a, input int b, input int c,
                                        input int d, input int e);
    in_item_t f;
    f.sensor_0 = 10'(a);
    f.sensor_1 = 10'(b);
    f.sensor_2 = 10'(c);
    f.sensor_3 = 10'(d);
    f.sensor_4 = 10'(e);
    return f;
  endfunction

  // Random frame. Mostly a plausible line profile (bright bump round a random centre),
  // then lost-line frames, readings at the threshold, extreme codes, small jitter on the
  // previous frame (drives the colour class round its limits) and plain noise.
  function automatic in_item_t random_frame(input bit inv, input int thr);
    int v[LINE_LANES];
    int extremes[8];
    int kind, centre, spread, d, lo, i;
    in_item_t f;
    extremes = '{0, 1, 511, 512, 999, 1000, 1001, 1023};
    kind   = $urandom_range(99);
    centre = $urandom_range(4000);
    spread = $urandom_range(300, 1500);
    lo     = (thr > LINE_FULL) ? 0 : LINE_FULL - thr;
    for (i = 0; i < LINE_LANES; i++) begin
      d = i * LINE_FULL - centre;
      if (d < 0) d = -d;
      if (kind < 45) begin
        v[i] = (d < spread) ? LINE_FULL - d * LINE_FULL / spread : 0;
        v[i] += $urandom_range(40);
        if (v[i] > LINE_FULL) v[i] = LINE_FULL;
        if (inv) v[i] = LINE_FULL - v[i];
      end else if (kind < 55) begin
        // nothing passes the threshold
        v[i] = inv ? $urandom_range(1023, lo) : $urandom_range(thr, 0);
      end else if (kind < 65) begin
        case ($urandom_range(2))
          0: v[i] = inv ? LINE_FULL - thr : thr;
          1: v[i] = inv ? LINE_FULL - thr - 1 : thr + 1;
          default: v[i] = $urandom_range(1023);
        endcase
        if (v[i] < 0) v[i] = 0;
        if (v[i] > 1023) v[i] = 1023;
      end else if (kind < 75) begin
        v[i] = extremes[$urandom_range(7)];
      end else if (kind < 88) begin
        v[i] = int'(i == 0 ? last_frame.sensor_0 : i == 1 ? last_frame.sensor_1 :
                    i == 2 ? last_frame.sensor_2 : i == 3 ? last_frame.sensor_3 :
                    last_frame.sensor_4) + $urandom_range(20) - 10;
        if (v[i] < 0) v[i] = 0;
        if (v[i] > 1023) v[i] = 1023;
      end else begin
        v[i] = $urandom_range(1023);
      end
    end
    f = mk_frame(v[0], v[1], v[2], v[3], v[4]);
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  typedef struct {
    bit inv;
    int thr;
    int count;
    bit gaps;
  } phase_t;

  initial begin
    phase_t plan[10];
    in_item_t directed[$];
    int p, k;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    gaps_on    = 1'b1;
    last_frame = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset settings (no inversion, threshold 50)
    directed = '{
      mk_frame(0, 0, 0, 0, 0),                // lost straight out of reset: left edge
      mk_frame(1023, 1023, 1023, 1023, 1023), // every bit set, readings over full scale
      mk_frame(1000, 1000, 1000, 1000, 1000),
      mk_frame(1000, 0, 0, 0, 0),
      mk_frame(0, 0, 0, 0, 1000),             // hard left to hard right: steer maximum
      mk_frame(1000, 0, 0, 0, 0),             // and back: steer minimum
      mk_frame(0, 1000, 0, 0, 0),
      mk_frame(0, 0, 0, 1000, 0),
      mk_frame(0, 0, 1000, 0, 0),             // dead centre
      mk_frame(0, 0, 0, 0, 0),                // lost with last position exactly at centre
      mk_frame(0, 0, 0, 0, 1023),
      mk_frame(0, 0, 0, 0, 0),                // lost on the right
      mk_frame(0, 0, 0, 0, 0),                // still lost, colour sum unchanged at zero
      mk_frame(50, 50, 50, 50, 50),           // readings equal to threshold do not count
      mk_frame(51, 50, 50, 50, 50),           // one just above it
      mk_frame(80, 80, 80, 80, 80),
      mk_frame(80, 80, 80, 80, 80),           // colour value exactly at the black limit
      mk_frame(81, 80, 80, 80, 80),
      mk_frame(81, 80, 80, 80, 80),           // one over the black limit
      mk_frame(12, 0, 0, 0, 0),               // big drop: unknown
      mk_frame(13, 0, 0, 0, 0),
      mk_frame(12, 0, 0, 0, 0),               // colour value exactly zero: green
      mk_frame(11, 0, 0, 0, 0),               // colour value minus one: unknown
      mk_frame(600, 700, 300, 1000, 1)
    };
    foreach (directed[k]) send_request(directed[k]);

    // Random phases over several settings, extremes among them. The first one runs
    // with no idling at all; every phase boundary drains the core completely.
    plan = '{
      '{1'b0, 50,   400, 1'b0},
      '{1'b1, 50,   300, 1'b1},
      '{1'b0, 0,    200, 1'b1},
      '{1'b1, 0,    200, 1'b1},
      '{1'b0, 1000, 150, 1'b1},
      '{1'b1, 1000, 150, 1'b1},
      '{1'b0, 0,    200, 1'b1},
      '{1'b1, 0,    200, 1'b1},
      '{1'b0, 1023, 50,  1'b1},
      '{1'b1, 1023, 50,  1'b1}
    };
    plan[6].thr = $urandom_range(1000);
    plan[7].thr = $urandom_range(1000);

    for (p = 0; p < 10; p++) begin
      wait_drained();
      write_reg(REG_INVERT, 32'(plan[p].inv));
      write_reg(REG_THRESH, 32'(plan[p].thr));
      gaps_on = plan[p].gaps;
      for (k = 0; k < plan[p].count; k++)
        send_request(random_frame(plan[p].inv, plan[p].thr));
    end

    wait_drained();
    gaps_on = 1'b0;
    repeat (30) @(posedge clk);
    if (sb.fails == 0 && sb.expected_steer.size() == 0) begin
      $display("line_position_pd_steering_core: match");
    end else begin
      $display("line_position_pd_steering_core: mismatch");
    end
    $finish;
  end

endmodule
